@@ src/mcp0exc_pkg.sv @@
// Shared types, operation codes, vector addresses and cause priority table
// for the coprocessor 0 exception unit. No dependencies.
package mcp0exc_pkg;

   localparam int PcWidth = 32;
   localparam int ReqDataWidth = 64;
   localparam int RspDataWidth = 120;

   localparam logic [PcWidth-1:0] VecBootGeneral = 32'hBFC0_0380;
   localparam logic [PcWidth-1:0] VecGeneral     = 32'h8000_0180;
   localparam logic [PcWidth-1:0] VecReset       = 32'hBFC0_0000;
   localparam logic [PcWidth-1:0] InsnBytes      = 32'd4;
   localparam logic [4:0]         CodeInt        = 5'd0;

   typedef enum logic [2:0] {
      OP_SET_IRQ      = 3'd0,
      OP_CLEAR_IRQ    = 3'd1,
      OP_RAISE        = 3'd2,
      OP_RESET        = 3'd3,
      OP_PROCESS      = 3'd4,
      OP_WRITE_STATUS = 3'd5
   } op_type;

   typedef struct packed {
      op_type               operation;
      logic [7:0]           irq_mask;
      logic [4:0]           exc_code;
      logic [1:0]           cop_unit;
      logic [PcWidth-1:0]   current_pc;
      logic                 in_delay_slot;
      logic                 new_ie;
      logic [7:0]           new_im;
      logic                 new_exl;
      logic                 new_erl;
      logic                 new_bev;
   } req_item_type;

   typedef struct packed {
      logic                 redirect;
      logic [PcWidth-1:0]   next_pc;
      logic [PcWidth-1:0]   epc_out;
      logic [PcWidth-1:0]   error_epc_out;
      logic                 branch_delay;
      logic [4:0]           exc_code_out;
      logic [1:0]           coproc_out;
      logic [7:0]           ip_out;
      logic                 exl_out;
      logic                 erl_out;
      logic                 bev_out;
   } rsp_item_type;

   // smaller number is more urgent; reserved codes are least urgent
   function automatic logic [6:0] cause_prio(input logic [4:0] code);
      logic [6:0] prio;
      case (code)
         5'd0:    prio = 7'd31;
         5'd1:    prio = 7'd27;
         5'd2:    prio = 7'd26;
         5'd3:    prio = 7'd25;
         5'd4:    prio = 7'd24;
         5'd5:    prio = 7'd23;
         5'd6:    prio = 7'd21;
         5'd7:    prio = 7'd30;
         5'd8,
         5'd9,
         5'd10,
         5'd11,
         5'd12,
         5'd13,
         5'd15:   prio = 7'd22;
         5'd14:   prio = 7'd20;
         5'd23:   prio = 7'd28;
         5'd31:   prio = 7'd29;
         default: prio = 7'd99;
      endcase
      return prio;
   endfunction

endpackage

@@ src/mcp0exc_core.sv @@
// Architectural state of the exception unit and the single-pass update for
// one request. Depends on mcp0exc_pkg.
module mcp0exc_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  mcp0exc_pkg::req_item_type   item,
   output mcp0exc_pkg::rsp_item_type   result
);

   logic [7:0]  pending_ip_ff, pending_ip_in;
   logic [4:0]  cause_code_ff, cause_code_in;
   logic [1:0]  cause_coproc_ff, cause_coproc_in;
   logic        cause_bd_ff, cause_bd_in;
   logic [mcp0exc_pkg::PcWidth-1:0] epc_ff, epc_in;
   logic [mcp0exc_pkg::PcWidth-1:0] error_epc_ff, error_epc_in;
   logic        exc_pending_ff, exc_pending_in;
   logic        ie_ff, ie_in;
   logic [7:0]  im_ff, im_in;
   logic        exl_ff, exl_in;
   logic        erl_ff, erl_in;
   logic        bev_ff, bev_in;
   logic        redirect;
   logic [mcp0exc_pkg::PcWidth-1:0] target;
   logic        irq_taken;
   logic        raise_ok;

   assign irq_taken = ie_ff && ((pending_ip_ff & im_ff) != 8'd0) && !exl_ff && !erl_ff;
   assign raise_ok  = !exl_ff && !erl_ff &&
                      (mcp0exc_pkg::cause_prio(item.exc_code) <=
                       mcp0exc_pkg::cause_prio(cause_code_ff));

   always_comb begin
      pending_ip_in   = pending_ip_ff;
      cause_code_in   = cause_code_ff;
      cause_coproc_in = cause_coproc_ff;
      cause_bd_in     = cause_bd_ff;
      epc_in          = epc_ff;
      error_epc_in    = error_epc_ff;
      exc_pending_in  = exc_pending_ff;
      ie_in           = ie_ff;
      im_in           = im_ff;
      exl_in          = exl_ff;
      erl_in          = erl_ff;
      bev_in          = bev_ff;
      redirect        = 1'b0;
      target          = '0;
      case (item.operation)
         mcp0exc_pkg::OP_SET_IRQ: begin
            pending_ip_in = pending_ip_ff | item.irq_mask;
         end
         mcp0exc_pkg::OP_CLEAR_IRQ: begin
            pending_ip_in = pending_ip_ff & ~item.irq_mask;
         end
         mcp0exc_pkg::OP_RAISE: begin
            if (raise_ok) begin
               cause_code_in   = item.exc_code;
               cause_coproc_in = item.cop_unit;
               exc_pending_in  = 1'b1;
            end
         end
         mcp0exc_pkg::OP_RESET: begin
            bev_in       = 1'b1;
            erl_in       = 1'b1;
            error_epc_in = item.current_pc;
            redirect     = 1'b1;
            target       = mcp0exc_pkg::VecReset;
         end
         mcp0exc_pkg::OP_PROCESS: begin
            if (exc_pending_ff || irq_taken) begin
               if (exc_pending_ff) begin
                  exc_pending_in = 1'b0;
               end else begin
                  cause_code_in = mcp0exc_pkg::CodeInt;
               end
               cause_bd_in = item.in_delay_slot;
               epc_in      = item.in_delay_slot ?
                             item.current_pc - mcp0exc_pkg::InsnBytes : item.current_pc;
               exl_in      = 1'b1;
               redirect    = 1'b1;
               target      = bev_ff ? mcp0exc_pkg::VecBootGeneral
                                    : mcp0exc_pkg::VecGeneral;
            end
         end
         mcp0exc_pkg::OP_WRITE_STATUS: begin
            ie_in  = item.new_ie;
            im_in  = item.new_im;
            exl_in = item.new_exl;
            erl_in = item.new_erl;
            bev_in = item.new_bev;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result.redirect      = redirect;
      result.next_pc       = target;
      result.epc_out       = epc_in;
      result.error_epc_out = error_epc_in;
      result.branch_delay  = cause_bd_in;
      result.exc_code_out  = cause_code_in;
      result.coproc_out    = cause_coproc_in;
      result.ip_out        = pending_ip_in;
      result.exl_out       = exl_in;
      result.erl_out       = erl_in;
      result.bev_out       = bev_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ip_ff   <= '0;
         cause_code_ff   <= mcp0exc_pkg::CodeInt;
         cause_coproc_ff <= '0;
         cause_bd_ff     <= 1'b0;
         epc_ff          <= '0;
         error_epc_ff    <= '0;
         exc_pending_ff  <= 1'b0;
         ie_ff           <= 1'b0;
         im_ff           <= '0;
         exl_ff          <= 1'b0;
         erl_ff          <= 1'b1;
         bev_ff          <= 1'b1;
      end else if (step) begin
         pending_ip_ff   <= pending_ip_in;
         cause_code_ff   <= cause_code_in;
         cause_coproc_ff <= cause_coproc_in;
         cause_bd_ff     <= cause_bd_in;
         epc_ff          <= epc_in;
         error_epc_ff    <= error_epc_in;
         exc_pending_ff  <= exc_pending_in;
         ie_ff           <= ie_in;
         im_ff           <= im_in;
         exl_ff          <= exl_in;
         erl_ff          <= erl_in;
         bev_ff          <= bev_in;
      end
   end

endmodule

@@ src/mips_cp0_exception_unit.sv @@
// Top level of the coprocessor 0 exception unit: request register, state core
// and response register. Depends on mcp0exc_pkg and mcp0exc_core.
//
// Each request on the req_ channel is one event: set or clear pending
// interrupt bits, raise an exception, apply a CPU reset, process (take an
// exception now if one is due) or write the status bits. The operation
// code travels in req_tuser, all other fields in req_tdata.
// Every request yields exactly one response on the rsp_ channel. rsp_tuser
// carries the redirect flag, rsp_tdata the vector address and the state of
// EPC, ErrorEPC, cause and status after the update.
// A request accepted on the req_ channel lands in the request register; its
// result is captured in the response register and shown as a valid response.
// Throughput: one request per cycle while rsp_tready is high; the state
// update for a request is one pass of logic, so the next may follow at once.
// When the receiver holds rsp_tready low the response holds, one further
// request waits in the request register, and req_tready drops after that.
// Reset (synchronous, active high) empties both registers and sets the
// state to its power-on values: BEV and ERL set, everything else zero.
module mips_cp0_exception_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // irq_mask[7:0], exc_code[12:8], cop_unit[14:13], current_pc[46:15],
   // in_delay_slot[47], new_ie[48], new_im[56:49], new_exl[57], new_erl[58],
   // new_bev[59], zero[63:60]
   input  logic [mcp0exc_pkg::ReqDataWidth-1:0]  req_tdata,
   // operation[2:0]
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // next_pc[31:0], epc_out[63:32], error_epc_out[95:64], branch_delay[96],
   // exc_code_out[101:97], coproc_out[103:102], ip_out[111:104], exl_out[112],
   // erl_out[113], bev_out[114], zero[119:115]
   output logic [mcp0exc_pkg::RspDataWidth-1:0] rsp_tdata,
   // redirect[0]
   output logic         rsp_tuser
);

   logic                       req_valid_ff, req_valid_in;
   mcp0exc_pkg::req_item_type  req_item_ff, req_item_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   mcp0exc_pkg::rsp_item_type  rsp_item_ff;
   mcp0exc_pkg::rsp_item_type  result;
   logic                       out_free;
   logic                       advance;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = req_valid_ff && out_free;
   assign req_tready = !req_valid_ff || out_free;

   always_comb begin
      req_item_in.operation     = mcp0exc_pkg::op_type'(req_tuser);
      req_item_in.irq_mask      = req_tdata[7:0];
      req_item_in.exc_code      = req_tdata[12:8];
      req_item_in.cop_unit      = req_tdata[14:13];
      req_item_in.current_pc    = req_tdata[46:15];
      req_item_in.in_delay_slot = req_tdata[47];
      req_item_in.new_ie        = req_tdata[48];
      req_item_in.new_im        = req_tdata[56:49];
      req_item_in.new_exl       = req_tdata[57];
      req_item_in.new_erl       = req_tdata[58];
      req_item_in.new_bev       = req_tdata[59];
   end

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_tready) begin
         req_valid_in = req_tvalid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = req_valid_ff;
      end
   end

   mcp0exc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (req_item_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_item_ff <= req_item_in;
      end
      if (advance) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_item_ff.redirect;
   assign rsp_tdata  = {5'd0,
                        rsp_item_ff.bev_out,
                        rsp_item_ff.erl_out,
                        rsp_item_ff.exl_out,
                        rsp_item_ff.ip_out,
                        rsp_item_ff.coproc_out,
                        rsp_item_ff.exc_code_out,
                        rsp_item_ff.branch_delay,
                        rsp_item_ff.error_epc_out,
                        rsp_item_ff.epc_out,
                        rsp_item_ff.next_pc};

   a_redirect_vector: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rsp_item_ff.next_pc == mcp0exc_pkg::VecReset ||
         rsp_item_ff.next_pc == mcp0exc_pkg::VecGeneral ||
         rsp_item_ff.next_pc == mcp0exc_pkg::VecBootGeneral)
      else $error("redirect to an address that is no vector");

   a_no_redirect_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_item_ff.next_pc == '0)
      else $error("next_pc nonzero without redirect");

   a_taken_sets_exl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && rsp_item_ff.next_pc != mcp0exc_pkg::VecReset |->
         rsp_item_ff.exl_out)
      else $error("exception taken without EXL set");

   a_reset_vector_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && rsp_item_ff.next_pc == mcp0exc_pkg::VecReset |->
         rsp_item_ff.erl_out && rsp_item_ff.bev_out)
      else $error("reset vector without ERL and BEV");

   a_request_held: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !out_free |=> req_valid_ff && $stable(req_item_ff))
      else $error("stalled request lost");

endmodule

@@ dv/testbench.sv @@
// Self-checking bench for mips_cp0_exception_unit: directed table, then weighted random
// events, each response checked against a fixed table value or a local predictor of cause,
// EPC and status state. Depends on mcp0exc_pkg and the RTL under src.
module testbench;

   localparam logic [2:0] OpSpareA = 3'd6;
   localparam logic [2:0] OpSpareB = 3'd7;
   localparam int unsigned RandomEvents = 1726;
   localparam int unsigned PausePoint = 900;
   localparam int unsigned HoldPoint = 500;
   localparam int unsigned HoldCycles = 300;
   localparam int unsigned WatchdogLimit = 5000;

   // lower rank is more urgent
   localparam logic [6:0] CauseRank [32] = '{
      7'd31, 7'd27, 7'd26, 7'd25, 7'd24, 7'd23, 7'd21, 7'd30,
      7'd22, 7'd22, 7'd22, 7'd22, 7'd22, 7'd22, 7'd20, 7'd22,
      7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd28,
      7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd29
   };

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  irq;
      logic [4:0]  code;
      logic [1:0]  cop;
      logic [31:0] pc;
      logic        dslot;
      logic        ie;
      logic [7:0]  im;
      logic        exl;
      logic        erl;
      logic        bev;
   } cp0_event_type;

   typedef struct packed {
      logic [7:0]  ip;
      logic [4:0]  code;
      logic [1:0]  cop;
      logic        bd;
      logic [31:0] epc;
      logic [31:0] err_epc;
      logic        latched;
      logic        ie;
      logic [7:0]  im;
      logic        exl;
      logic        erl;
      logic        bev;
   } cp0_state_type;

   typedef struct packed {
      cp0_event_type              ev;
      logic                       fixed;
      mcp0exc_pkg::rsp_item_type  want;
   } directed_row_type;

   localparam mcp0exc_pkg::rsp_item_type Unchecked = '0;

   localparam directed_row_type DirectedRows [24] = '{
      '{'{mcp0exc_pkg::OP_PROCESS, 8'h00, 5'd0, 2'd0, 32'h0000_0000, 1'b0, 1'b0, 8'h00,
          1'b0, 1'b0, 1'b0},
        1'b1, '{1'b0, 32'h0, 32'h0, 32'h0, 1'b0, 5'd0, 2'd0, 8'h00, 1'b0, 1'b1, 1'b1}},
      '{'{mcp0exc_pkg::OP_RAISE, 8'h00, 5'd31, 2'd3, 32'h0000_0000, 1'b0, 1'b0, 8'h00,
          1'b0, 1'b0, 1'b0},
        1'b0, Unchecked},
      '{'{mcp0exc_pkg::OP_RESET, 8'h00, 5'd0, 2'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'h00,
          1'b0, 1'b0, 1'b0},
        1'b1, '{1'b1, mcp0exc_pkg::VecReset, 32'h0, 32'hFFFF_FFFF, 1'b0, 5'd0, 2'd0, 8'h00,
        1'b0, 1'b1, 1'b1}},
      '{'{mcp0exc_pkg::OP_SET_IRQ, 8'hFF, 5'd0, 2'd0, 32'h0000_0000, 1'b0, 1'b0, 8'h00,
          1'b0, 1'b0, 1'b0},
        1'b0, Unchecked},
      '{'{mcp0exc_pkg::OP_CLEAR_IRQ, 8'h0F, 5'd0, 2'd0, 32'h0000_0000, 1'b0, 1'b0, 8'h00,
          1'b0, 1'b0, 1'b0},
        1'b0, Unchecked},
      '{'{mcp0exc_pkg::OP_WRITE_STATUS, 8'h00, 5'd0, 2'd0, 32'h0, 1'b0, 1'b1, 8'hFF,
          1'b0, 1'b0, 1'b0},
        1'b0, Unchecked},
      '{'{mcp0exc_pkg::OP_PROCESS, 8'h00, 5'd0, 2'd0, 32'h0000_0000, 1'b1, 1'b0, 8'h00,
          1'b0, 1'b0, 1'b0},
        1'b1, '{1'b1, mcp0exc_pkg::VecGeneral, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b1, 5'd0,
        2'd0, 8'hF0, 1'b1, 1'b0, 1'b0}},
      '{'{mcp0exc_pkg::OP_RAISE, 8'h00, 5'd1, 2'd1, 32'h0000_0000, 1'b0, 1'b0, 8'h00,
          1'b0, 1'b0, 1'b0},
        1'b0, Unchecked},
      '{'{mcp0exc_pkg::OP_WRITE_STATUS, 8'h00, 5'd0, 2'd0, 32'h0, 1'b0, 1'b0, 8'h00,
          1'b0, 1'b0, 1'b1},
        1'b0, Unchecked},
      '{'{mcp0exc_pkg::OP_RAISE, 8'h00, 5'd31, 2'd3, 32'h0000_0000, 1'b0, 1'b0, 8'h00,
          1'b0, 1'b0, 1'b0},
        1'b0, Unchecked},
      '{'{mcp0exc_pkg::OP_RAISE, 8'h00, 5'd16, 2'd1, 32'h0000_0000, 1'b0, 1'b0, 8'h00,
          1'b0, 1'b0, 1'b0},
        1'b0, Unchecked},
      '{'{mcp0exc_pkg::OP_RAISE, 8'h00, 5'd14, 2'd2, 32'h0000_0000, 1'b0, 1'b0, 8'h00,
          1'b0, 1'b0, 1'b0},
        1'b0, Unchecked},
      '{'{mcp0exc_pkg::OP_RAISE, 8'h00, 5'd0, 2'd1, 32'h0000_0000, 1'b0, 1'b0, 8'h00,
          1'b0, 1'b0, 1'b0},
        1'b0, Unchecked},
      '{'{mcp0exc_pkg::OP_WRITE_STATUS, 8'h00, 5'd0, 2'd0, 32'h0, 1'b0, 1'b1, 8'hFF,
          1'b1, 1'b1, 1'b1},
        1'b0, Unchecked},
      '{'{mcp0exc_pkg::OP_PROCESS, 8'h00, 5'd0, 2'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'h00,
          1'b0, 1'b0, 1'b0},
        1'b0, Unchecked},
      '{'{OpSpareA, 8'hFF, 5'd31, 2'd3, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b1},
        1'b0, Unchecked},
      '{'{OpSpareB, 8'hFF, 5'd31, 2'd3, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b1},
        1'b0, Unchecked},
      '{'{mcp0exc_pkg::OP_CLEAR_IRQ, 8'hFF, 5'd0, 2'd0, 32'h0000_0000, 1'b0, 1'b0, 8'h00,
          1'b0, 1'b0, 1'b0},
        1'b0, Unchecked},
      '{'{mcp0exc_pkg::OP_WRITE_STATUS, 8'h00, 5'd0, 2'd0, 32'h0, 1'b0, 1'b1, 8'hFF,
          1'b0, 1'b0, 1'b0},
        1'b0, Unchecked},
      '{'{mcp0exc_pkg::OP_PROCESS, 8'h00, 5'd0, 2'd0, 32'h0000_1234, 1'b0, 1'b0, 8'h00,
          1'b0, 1'b0, 1'b0},
        1'b0, Unchecked},
      '{'{mcp0exc_pkg::OP_RAISE, 8'h00, 5'd7, 2'd0, 32'h0000_0000, 1'b0, 1'b0, 8'h00,
          1'b0, 1'b0, 1'b0},
        1'b0, Unchecked},
      '{'{mcp0exc_pkg::OP_SET_IRQ, 8'h01, 5'd0, 2'd0, 32'h0000_0000, 1'b0, 1'b0, 8'h00,
          1'b0, 1'b0, 1'b0},
        1'b0, Unchecked},
      '{'{mcp0exc_pkg::OP_PROCESS, 8'h00, 5'd0, 2'd0, 32'h8000_0004, 1'b1, 1'b0, 8'h00,
          1'b0, 1'b0, 1'b0},
        1'b0, Unchecked},
      '{'{mcp0exc_pkg::OP_RESET, 8'h00, 5'd0, 2'd0, 32'h0000_0000, 1'b0, 1'b0, 8'h00,
          1'b0, 1'b0, 1'b0},
        1'b0, Unchecked}
   };

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [63:0]  req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [119:0] rsp_tdata;
   logic         rsp_tuser;

   cp0_state_type              cp0;
   mcp0exc_pkg::rsp_item_type  awaited_views [$];
   int unsigned  mismatches = 0;
   int unsigned  responses_seen = 0;
   int unsigned  idle_cycles = 0;

   mips_cp0_exception_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic mcp0exc_pkg::rsp_item_type cp0_next_view(input cp0_event_type ev);
      mcp0exc_pkg::rsp_item_type view;
      logic                      irq_due;
      view = '0;
      case (ev.op)
         mcp0exc_pkg::OP_SET_IRQ: cp0.ip = cp0.ip | ev.irq;
         mcp0exc_pkg::OP_CLEAR_IRQ: cp0.ip = cp0.ip & ~ev.irq;
         mcp0exc_pkg::OP_RAISE: begin
            if (!cp0.exl && !cp0.erl && CauseRank[ev.code] <= CauseRank[cp0.code]) begin
               cp0.code = ev.code;
               cp0.cop = ev.cop;
               cp0.latched = 1'b1;
            end
         end
         mcp0exc_pkg::OP_RESET: begin
            cp0.bev = 1'b1;
            cp0.erl = 1'b1;
            cp0.err_epc = ev.pc;
            view.redirect = 1'b1;
            view.next_pc = mcp0exc_pkg::VecReset;
         end
         mcp0exc_pkg::OP_PROCESS: begin
            irq_due = cp0.ie && ((cp0.ip & cp0.im) != 8'h00) && !cp0.exl && !cp0.erl;
            if (cp0.latched || irq_due) begin
               if (cp0.latched) begin
                  cp0.latched = 1'b0;
               end else begin
                  cp0.code = mcp0exc_pkg::CodeInt;
               end
               cp0.bd = ev.dslot;
               cp0.epc = ev.dslot ? ev.pc - mcp0exc_pkg::InsnBytes : ev.pc;
               cp0.exl = 1'b1;
               view.redirect = 1'b1;
               view.next_pc = cp0.bev ? mcp0exc_pkg::VecBootGeneral
                                      : mcp0exc_pkg::VecGeneral;
            end
         end
         mcp0exc_pkg::OP_WRITE_STATUS: begin
            cp0.ie = ev.ie;
            cp0.im = ev.im;
            cp0.exl = ev.exl;
            cp0.erl = ev.erl;
            cp0.bev = ev.bev;
         end
         default: ;
      endcase
      view.epc_out = cp0.epc;
      view.error_epc_out = cp0.err_epc;
      view.branch_delay = cp0.bd;
      view.exc_code_out = cp0.code;
      view.coproc_out = cp0.cop;
      view.ip_out = cp0.ip;
      view.exl_out = cp0.exl;
      view.erl_out = cp0.erl;
      view.bev_out = cp0.bev;
      return view;
   endfunction

   function automatic cp0_event_type random_event();
      cp0_event_type ev;
      int unsigned   pick;
      pick = $urandom_range(0, 99);
      if (pick < 14) ev.op = mcp0exc_pkg::OP_SET_IRQ;
      else if (pick < 24) ev.op = mcp0exc_pkg::OP_CLEAR_IRQ;
      else if (pick < 50) ev.op = mcp0exc_pkg::OP_RAISE;
      else if (pick < 53) ev.op = mcp0exc_pkg::OP_RESET;
      else if (pick < 78) ev.op = mcp0exc_pkg::OP_PROCESS;
      else if (pick < 95) ev.op = mcp0exc_pkg::OP_WRITE_STATUS;
      else if (pick < 98) ev.op = OpSpareA;
      else ev.op = OpSpareB;
      ev.irq = 8'($urandom_range(0, 255));
      ev.code = 5'($urandom_range(0, 31));
      ev.cop = 2'($urandom_range(0, 3));
      pick = $urandom_range(0, 9);
      if (pick == 0) ev.pc = 32'($urandom_range(0, 7));
      else if (pick == 1) ev.pc = 32'hFFFF_FFFF - 32'($urandom_range(0, 7));
      else ev.pc = $urandom;
      ev.dslot = 1'($urandom_range(0, 1));
      ev.ie = ($urandom_range(0, 3) != 0);
      ev.im = 8'($urandom_range(0, 255));
      ev.exl = ($urandom_range(0, 4) == 0);
      ev.erl = ($urandom_range(0, 7) == 0);
      ev.bev = 1'($urandom_range(0, 1));
      return ev;
   endfunction

   function automatic int unsigned pick_gap(input bit steady);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic offer_event(input cp0_event_type ev, input logic fixed,
                              input mcp0exc_pkg::rsp_item_type want);
      mcp0exc_pkg::rsp_item_type view;
      req_tvalid <= 1'b1;
      req_tuser <= ev.op;
      req_tdata <= {4'b0, ev.bev, ev.erl, ev.exl, ev.im, ev.ie, ev.dslot, ev.pc, ev.cop,
                    ev.code, ev.irq};
      do @(posedge clock); while (!req_tready);
      view = cp0_next_view(ev);
      awaited_views.push_back(fixed ? want : view);
   endtask

   initial begin : request_side
      int unsigned   gap;
      int unsigned   n;
      cp0_event_type ev;
      cp0 = '0;
      cp0.erl = 1'b1;
      cp0.bev = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (n = 0; n < 24; n++) begin
         gap = pick_gap(1'b0);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         offer_event(DirectedRows[n].ev, DirectedRows[n].fixed, DirectedRows[n].want);
      end
      for (n = 0; n < RandomEvents; n++) begin
         if (n == PausePoint) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (awaited_views.size() != 0);
         end else begin
            gap = pick_gap((n / 150) % 3 == 1);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         ev = random_event();
         offer_event(ev, 1'b0, Unchecked);
      end
      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaited_views.size() != 0);
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("mips_cp0_exception_unit test passed");
      end else begin
         $display("mips_cp0_exception_unit test failed");
      end
      $finish;
   end

   initial begin : response_side
      int unsigned stall;
      bit          hold_done;
      hold_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && responses_seen >= HoldPoint) begin
            hold_done = 1'b1;
            stall = HoldCycles;
         end else begin
            stall = pick_gap((responses_seen / 200) % 3 == 2);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      mcp0exc_pkg::rsp_item_type got;
      mcp0exc_pkg::rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         responses_seen++;
         got = '{rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tdata[96],
                 rsp_tdata[101:97], rsp_tdata[103:102], rsp_tdata[111:104], rsp_tdata[112],
                 rsp_tdata[113], rsp_tdata[114]};
         if (awaited_views.size() == 0) begin
            mismatches++;
            $display("%0t: response with none expected, got %h / %h", $time, rsp_tuser,
                     rsp_tdata);
         end else begin
            want = awaited_views.pop_front();
            if (got !== want) begin
               mismatches++;
               $display("%0t: response expected %h, got %h", $time, want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("mips_cp0_exception_unit test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
